### rtl/core/http_request_header_parser_macros.svh
// Assertion macros for the HTTP request header parser.
// No dependencies.
`ifndef HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
`define HTTP_REQUEST_HEADER_PARSER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define HRP_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HRP_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/core/hrp_pkg.sv
// Shared types and constants for the HTTP request header parser.
// No dependencies.
package hrp_pkg;
    localparam int MAX_HEADER_BYTES = 8192;
    localparam int MAX_BODY_BYTES   = 16384;
    localparam logic [14:0] LEN_SAT = 15'd32767;
    localparam int NAME_LEN = 15;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;

    typedef enum logic [1:0] {PH_LINE, PH_HDR, PH_BODY, PH_IGN} t_phase;
    typedef enum logic [1:0] {VP_OFF, VP_NAME, VP_PRE, VP_DIG} t_vphase;
    typedef enum logic [2:0] {
        CL_METHOD, CL_PATH, CL_LINE, CL_HEADER, CL_BODY, CL_IGNORED
    } t_class;
    typedef enum logic [1:0] {ER_NONE, ER_HDR_LONG, ER_BAD_LINE, ER_BODY_LONG} t_err;
    typedef enum logic {CFG_HEADER_LIMIT, CFG_BODY_LIMIT} t_cfg_idx;

    typedef struct packed {
        t_class      byte_class;
        logic [7:0]  out_byte;
        logic        header_done;
        logic [14:0] body_len;
        logic        last;
        t_err        error;
    } t_result;

    function automatic logic [7:0] name_char(input logic [3:0] i);
        case (i)
            4'd0:  name_char = "c";
            4'd1:  name_char = "o";
            4'd2:  name_char = "n";
            4'd3:  name_char = "t";
            4'd4:  name_char = "e";
            4'd5:  name_char = "n";
            4'd6:  name_char = "t";
            4'd7:  name_char = "-";
            4'd8:  name_char = "l";
            4'd9:  name_char = "e";
            4'd10: name_char = "n";
            4'd11: name_char = "g";
            4'd12: name_char = "t";
            4'd13: name_char = "h";
            4'd14: name_char = ":";
            default: name_char = 8'h00;
        endcase
    endfunction
endpackage

### rtl/core/http_request_header_parser.sv
// Top level of the HTTP request header parser: config registers, front, queue.
// Depends on hrp_pkg, hrp_front and hrp_queue.
//  channel   dir   handshake                fields
//  request   in    i_push / o_full          i_start_req, i_in_byte
//  result    out   o_empty / i_pop          o_byte_class .. o_error
//  config    in    i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
// One byte per cycle while o_full is low. Parse state updates in the front part;
// a 4-entry queue decouples it from the result side, and each result reaches
// the outputs from the queue once earlier ones are popped. Synchronous active-low
// reset, no clearing pass. full rises only when four results wait unpopped.
module http_request_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_start_req,
    input  logic [7:0]  i_in_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [2:0]  o_byte_class,
    output logic [7:0]  o_out_byte,
    output logic        o_header_done,
    output logic [14:0] o_body_len,
    output logic        o_last,
    output logic [1:0]  o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import hrp_pkg::*;

    logic [13:0] r_hlim_raw;
    logic [14:0] r_blim_raw;
    logic [13:0] hlim;
    logic [14:0] blim;
    t_result     res, qout;
    logic        acc;

    assign o_cfg_ready = 1'b1;
    assign acc = i_push && !o_full;
    assign hlim = (r_hlim_raw > 14'(MAX_HEADER_BYTES)) ? 14'(MAX_HEADER_BYTES) :
                  (r_hlim_raw > 14'd16383) ? 14'd16383 : r_hlim_raw;
    assign blim = (r_blim_raw > 15'(MAX_BODY_BYTES)) ? 15'(MAX_BODY_BYTES) :
                  (r_blim_raw > 15'd32766) ? 15'd32766 : r_blim_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hlim_raw <= 14'd8192;
            r_blim_raw <= 15'd16384;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HEADER_LIMIT: r_hlim_raw <= i_cfg_data[13:0];
                CFG_BODY_LIMIT:   r_blim_raw <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hrp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(acc),
        .i_start_req(i_start_req), .i_in_byte(i_in_byte),
        .i_hlim(hlim), .i_blim(blim), .o_res(res)
    );

    hrp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(acc), .i_data(res),
        .o_full(o_full), .i_pop(i_pop), .o_empty(o_empty), .o_data(qout)
    );

    assign o_byte_class     = qout.byte_class;
    assign o_out_byte       = qout.out_byte;
    assign o_header_done    = qout.header_done;
    assign o_body_len       = qout.body_len;
    assign o_last           = qout.last;
    assign o_error          = qout.error;
endmodule

### rtl/core/hrp_front.sv
// Front part: classifies each byte and updates the request parse state.
// Depends on hrp_pkg.
module hrp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req,
    input  logic            i_start_req,
    input  logic [7:0]      i_in_byte,
    input  logic [13:0]     i_hlim,
    input  logic [14:0]     i_blim,
    output hrp_pkg::t_result o_res
);
    import hrp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [13:0] r_hcnt, n_hcnt;
    logic [1:0]  r_trun, n_trun;
    logic [1:0]  r_spc, n_spc;
    logic        r_skip, n_skip;
    logic [3:0]  r_midx, n_midx;
    t_vphase     r_vph, n_vph;
    logic        r_neg, n_neg;
    logic [14:0] r_len, n_len;
    logic [14:0] r_rem, n_rem;

    logic [7:0]  b, lc;
    logic        term, ws, dig;
    logic [18:0] mul;
    logic [14:0] dval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LINE;
            r_hcnt  <= '0;
            r_trun  <= '0;
            r_spc   <= '0;
            r_skip  <= 1'b0;
            r_midx  <= '0;
            r_vph   <= VP_OFF;
            r_neg   <= 1'b0;
            r_len   <= '0;
            r_rem   <= '0;
        end else if (i_req) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_trun  <= n_trun;
            r_spc   <= n_spc;
            r_skip  <= n_skip;
            r_midx  <= n_midx;
            r_vph   <= n_vph;
            r_neg   <= n_neg;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

    always_comb begin
        b    = i_in_byte;
        lc   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        ws   = (b == " ") || (b == 8'h09) || (b == 8'h0A) || (b == 8'h0B) || (b == 8'h0C);
        dig  = (b >= "0") && (b <= "9");
        term = 1'b0;
        o_res = '{CL_IGNORED, b, 1'b0, 15'd0, 1'b0, ER_NONE};
        n_phase = r_phase; n_hcnt = r_hcnt; n_trun = r_trun; n_spc = r_spc;
        n_skip = r_skip; n_midx = r_midx; n_vph = r_vph; n_neg = r_neg;
        n_len = r_len; n_rem = r_rem;
        if (i_start_req) begin
            n_phase = PH_LINE; n_hcnt = '0; n_trun = '0; n_spc = '0; n_skip = 1'b0;
            n_midx = '0; n_vph = VP_OFF; n_neg = 1'b0; n_len = '0; n_rem = '0;
        end
        mul  = {1'b0, n_len, 3'b000} + {3'b000, n_len, 1'b0} + {11'd0, b - 8'd48};
        dval = (mul > {4'd0, LEN_SAT}) ? LEN_SAT : mul[14:0];
        case (n_phase)
            PH_BODY: begin
                o_res.byte_class = CL_BODY;
                if (n_rem != '0) n_rem = n_rem - 15'd1;
                if (n_rem == '0) begin
                    o_res.last = 1'b1;
                    n_phase = PH_IGN;
                end
            end
            PH_LINE, PH_HDR: begin
                n_hcnt = n_hcnt + 14'd1;
                if (b == 8'h0D) n_trun = (n_trun == 2'd2) ? 2'd3 : 2'd1;
                else if (b == 8'h0A) begin
                    if (n_trun == 2'd3) begin
                        term = 1'b1;
                        n_trun = '0;
                    end else n_trun = (n_trun == 2'd1) ? 2'd2 : 2'd0;
                end else n_trun = '0;
                if (n_phase == PH_LINE) begin
                    if (b == 8'h0D) begin
                        o_res.byte_class = CL_LINE;
                        if (n_spc < 2'd2) o_res.error = ER_BAD_LINE;
                        else begin
                            n_phase = PH_HDR; n_skip = 1'b1; n_midx = '0; n_vph = VP_NAME;
                        end
                    end else if (b == " ") begin
                        o_res.byte_class = CL_LINE;
                        if (n_spc < 2'd2) n_spc = n_spc + 2'd1;
                    end else begin
                        o_res.byte_class = (n_spc == 2'd0) ? CL_METHOD :
                                           (n_spc == 2'd1) ? CL_PATH : CL_LINE;
                    end
                end else begin
                    o_res.byte_class = CL_HEADER;
                    if (b == 8'h0D) begin
                        n_skip = 1'b1; n_midx = '0; n_vph = VP_NAME;
                    end else if (n_skip) n_skip = 1'b0;
                    else begin
                        case (n_vph)
                            VP_NAME: begin
                                if (lc == name_char(n_midx)) begin
                                    n_midx = n_midx + 4'd1;
                                    if (n_midx == 4'(NAME_LEN)) begin
                                        n_vph = VP_PRE; n_len = '0; n_neg = 1'b0;
                                        n_rem = '0;
                                    end
                                end else n_vph = VP_OFF;
                            end
                            VP_PRE: begin
                                if (ws) begin
                                end else if (b == "+" || b == "-") begin
                                    n_neg = (b == "-");
                                    n_vph = VP_DIG;
                                    n_rem = (n_neg && n_len != '0) ? LEN_SAT : n_len;
                                end else if (dig) begin
                                    n_vph = VP_DIG;
                                    n_len = dval;
                                    n_rem = (n_neg && n_len != '0) ? LEN_SAT : n_len;
                                end else n_vph = VP_OFF;
                            end
                            VP_DIG: begin
                                if (dig) begin
                                    n_len = dval;
                                    n_rem = (n_neg && n_len != '0) ? LEN_SAT : n_len;
                                end else n_vph = VP_OFF;
                            end
                            default: ;
                        endcase
                    end
                end
                if (term) begin
                    o_res.header_done = 1'b1;
                    o_res.error = ER_NONE;
                    if (n_rem > i_blim) begin
                        o_res.error = ER_BODY_LONG; o_res.last = 1'b1; n_phase = PH_IGN;
                    end else begin
                        o_res.body_len = n_rem;
                        if (n_rem == '0) begin
                            o_res.last = 1'b1; n_phase = PH_IGN;
                        end else n_phase = PH_BODY;
                    end
                end else begin
                    if (o_res.error == ER_NONE && n_hcnt >= i_hlim)
                        o_res.error = ER_HDR_LONG;
                    if (o_res.error != ER_NONE) begin
                        o_res.last = 1'b1; n_phase = PH_IGN;
                    end
                end
            end
            default: ;
        endcase
    end
endmodule

### rtl/core/hrp_queue.sv
// Result queue between the front part and the output ports.
// Depends on hrp_pkg and the assertion macro header.
module hrp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  hrp_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output hrp_pkg::t_result o_data
);
    import hrp_pkg::*;
    `include "http_request_header_parser_macros.svh"

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

    `HRP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (QAW+1)'(QDEPTH))
    `HRP_ASSERT_IMP(a_ptr_gap, i_clk, i_rst_n, 1'b1, r_wp == r_rp + r_cnt[QAW-1:0])
    `HRP_ASSERT_NEXT(a_push_only, i_clk, i_rst_n, do_push && !do_pop, !o_empty)
endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for http_request_header_parser: byte streams of
// well-formed, broken and noise requests, checked against a scoreboard model.
// Depends on hrp_pkg and the parser RTL.
module testbench;
    import hrp_pkg::*;

    logic        i_clk, i_rst_n;
    logic        i_push, i_start_req, i_pop;
    logic [7:0]  i_in_byte;
    logic        i_cfg_valid, i_cfg_index;
    logic [14:0] i_cfg_data;
    logic        o_full, o_empty, o_header_done, o_last, o_cfg_ready;
    logic [2:0]  o_byte_class;
    logic [7:0]  o_out_byte;
    logic [14:0] o_body_len;
    logic [1:0]  o_error;

    http_request_header_parser uut (.*);

    class parser_scoreboard;
        int unsigned hdr_limit, body_lim;
        t_phase      phase;
        t_vphase     vphase;
        int unsigned hdr_count, term_run, spaces, skip_cr, match_idx;
        int unsigned neg, len_val, body_left;
        t_result     expected_q[$];
        int          fails;

        function new();
            hdr_limit = 8192;
            body_lim  = 16384;
            fails     = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_LINE; vphase = VP_OFF;
            hdr_count = 0; term_run = 0; spaces = 0; skip_cr = 0;
            match_idx = 0; neg = 0; len_val = 0; body_left = 0;
        endfunction

        function void set_cfg(t_cfg_idx idx, logic [14:0] val);
            if (idx == CFG_HEADER_LIMIT) hdr_limit = val[13:0];
            else body_lim = val;
        endfunction

        function bit in_body();
            return phase == PH_BODY;
        endfunction

        function void commit_len();
            body_left = (neg != 0 && len_val != 0) ? 32767 : len_val;
        endfunction

        function void header_char(int unsigned b);
            int unsigned c, v;
            if (vphase == VP_NAME) begin
                c = (b >= "A" && b <= "Z") ? b + 32 : b;
                if (match_idx < NAME_LEN && c == name_char(match_idx[3:0])) begin
                    match_idx++;
                    if (match_idx == NAME_LEN) begin
                        vphase = VP_PRE; len_val = 0; neg = 0;
                        commit_len();
                    end
                end else begin
                    vphase = VP_OFF;
                end
                return;
            end
            if (vphase == VP_PRE) begin
                if (b == 32 || b == 9 || b == 10 || b == 11 || b == 12) return;
                if (b == "+" || b == "-") begin
                    neg = (b == "-");
                    vphase = VP_DIG;
                    commit_len();
                    return;
                end
                vphase = VP_DIG;
            end
            if (vphase == VP_DIG) begin
                if (b >= "0" && b <= "9") begin
                    v = len_val * 10 + (b - "0");
                    len_val = (v > 32767) ? 32767 : v;
                    commit_len();
                end else begin
                    vphase = VP_OFF;
                end
            end
        endfunction

        function void note_input(bit st, logic [7:0] bv);
            t_result     r;
            int unsigned b, hlim, blim;
            bit          term;
            b = bv;
            r.byte_class = CL_IGNORED; r.out_byte = bv; r.header_done = 0;
            r.body_len = 0; r.last = 0; r.error = ER_NONE;
            term = 0;
            if (st) clear();
            if (phase == PH_BODY) begin
                r.byte_class = CL_BODY;
                if (body_left > 0) body_left--;
                if (body_left == 0) begin
                    r.last = 1; phase = PH_IGN;
                end
            end else if (phase == PH_LINE || phase == PH_HDR) begin
                hlim = hdr_limit;
                if (hlim > MAX_HEADER_BYTES) hlim = MAX_HEADER_BYTES;
                if (hlim > 16383) hlim = 16383;
                hdr_count = (hdr_count + 1) & 16'h3FFF;
                if (b == 13) term_run = (term_run == 2) ? 3 : 1;
                else if (b == 10) begin
                    if (term_run == 3) begin
                        term = 1; term_run = 0;
                    end else term_run = (term_run == 1) ? 2 : 0;
                end else term_run = 0;
                if (phase == PH_LINE) begin
                    if (b == 13) begin
                        r.byte_class = CL_LINE;
                        if (spaces < 2) r.error = ER_BAD_LINE;
                        else begin
                            phase = PH_HDR; skip_cr = 1;
                            match_idx = 0; vphase = VP_NAME;
                        end
                    end else if (b == 32) begin
                        r.byte_class = CL_LINE;
                        if (spaces < 2) spaces++;
                    end else begin
                        r.byte_class = (spaces == 0) ? CL_METHOD :
                                       (spaces == 1) ? CL_PATH : CL_LINE;
                    end
                end else begin
                    r.byte_class = CL_HEADER;
                    if (b == 13) begin
                        skip_cr = 1; match_idx = 0; vphase = VP_NAME;
                    end else if (skip_cr) begin
                        skip_cr = 0;
                    end else begin
                        header_char(b);
                    end
                end
                if (term) begin
                    blim = body_lim;
                    if (blim > MAX_BODY_BYTES) blim = MAX_BODY_BYTES;
                    if (blim > 32766) blim = 32766;
                    r.header_done = 1; r.error = ER_NONE;
                    if (body_left > blim) begin
                        r.error = ER_BODY_LONG; r.last = 1; phase = PH_IGN;
                    end else begin
                        r.body_len = body_left[14:0];
                        if (body_left == 0) begin
                            r.last = 1; phase = PH_IGN;
                        end else phase = PH_BODY;
                    end
                end else begin
                    if (r.error == ER_NONE && hdr_count >= hlim) r.error = ER_HDR_LONG;
                    if (r.error != ER_NONE) begin
                        r.last = 1; phase = PH_IGN;
                    end
                end
            end
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_result(t_result got);
            t_result exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.byte_class !== exp_r.byte_class || got.out_byte !== exp_r.out_byte ||
                got.header_done !== exp_r.header_done ||
                got.body_len !== exp_r.body_len ||
                got.last !== exp_r.last || got.error !== exp_r.error)
                report($sformatf("byte %h: got cls%0d done%0d len%0d last%0d err%0d, exp cls%0d done%0d len%0d last%0d err%0d",
                    exp_r.out_byte, got.byte_class, got.header_done, got.body_len,
                    got.last, got.error, exp_r.byte_class, exp_r.header_done,
                    exp_r.body_len, exp_r.last, exp_r.error));
        endtask
    endclass

    parser_scoreboard sb = new();
    int        burst_left = 0;
    int        random_sent = 0;
    int        pop_mode = 0;
    int        pop_cycle = 0;
    logic [7:0] req_q[$];

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: check at each accepted pop; the pop stall pattern is redrawn at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 0;
        end else begin
            if (i_pop && !o_empty)
                sb.check_result({t_class'(o_byte_class), o_out_byte, o_header_done,
                                 o_body_len, o_last, t_err'(o_error)});
            pop_cycle++;
            if (pop_cycle % 64 == 0) pop_mode = $urandom_range(0, 3);
            case (pop_mode)
                0: i_pop <= 1;
                1: i_pop <= $urandom_range(0, 1);
                2: i_pop <= ($urandom_range(0, 3) == 0);
                default: i_pop <= ((pop_cycle % 32) >= 20);
            endcase
        end
    end

    task idle_cycles(int n);
        i_push <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task push_byte(bit st, logic [7:0] b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_push <= 1;
        i_start_req <= st;
        i_in_byte <= b;
        do @(posedge i_clk); while (o_full);
        sb.note_input(st, b);
        random_sent++;
    endtask

    task drain();
        i_push <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task write_cfg(t_cfg_idx idx, logic [14:0] val);
        drain();
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.set_cfg(idx, val);
    endtask

    function void add_str(string s);
        for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
    endfunction

    // sends req_q, with start on the first byte if with_start, then body bytes while the model expects body
    task send_req(bit with_start);
        for (int i = 0; i < req_q.size(); i++) push_byte(with_start && i == 0, req_q[i]);
        while (sb.in_body()) push_byte(0, $urandom_range(0, 255));
        req_q.delete();
    endtask

    function void build_cl_line(int val, bit negative);
        string nm;
        nm = "content-length:";
        for (int i = 0; i < nm.len(); i++)
            if (nm[i] >= "a" && nm[i] <= "z" && $urandom_range(0, 1)) nm[i] = nm[i] - 32;
        add_str(nm);
        repeat ($urandom_range(0, 2)) req_q.push_back(($urandom_range(0, 1)) ? 8'd32 : 8'd9);
        if (negative) add_str("-");
        else if ($urandom_range(0, 3) == 0) add_str("+");
        if (val >= 0) add_str($sformatf("%0d", val));
        if ($urandom_range(0, 2) == 0) add_str(" x");
    endfunction

    function void build_request();
        int nh, r;
        repeat ($urandom_range(1, 4)) req_q.push_back($urandom_range("A", "Z"));
        add_str(" /");
        repeat ($urandom_range(0, 3)) req_q.push_back($urandom_range("a", "z"));
        add_str(" H1\r\n");
        nh = $urandom_range(0, 2);
        for (int h = 0; h < nh; h++) begin
            r = $urandom_range(0, 9);
            if (r < 5) build_cl_line($urandom_range(0, 6), 0);
            else if (r == 5) build_cl_line(99999, 0);
            else if (r == 6) build_cl_line($urandom_range(0, 3), 1);
            else if (r == 7) build_cl_line(-1, 0);
            else add_str("X-a: b");
            add_str("\r\n");
        end
        add_str("\r\n");
    endfunction

    task random_traffic(int n);
        int kind, cut;
        int stop_at;
        stop_at = random_sent + n;
        while (random_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 14) begin
                build_request();
                send_req(1);
            end else if (kind < 17) begin
                build_request();
                cut = $urandom_range(1, req_q.size());
                while (req_q.size() > cut) void'(req_q.pop_back());
                send_req(1);
            end else begin
                repeat ($urandom_range(1, 8))
                    push_byte($urandom_range(0, 7) == 0, $urandom_range(0, 255));
            end
            if ($urandom_range(0, 15) == 0) drain();
        end
    endtask

    initial begin
        i_rst_n = 0; i_push = 0; i_start_req = 0; i_in_byte = 0;
        i_cfg_valid = 0; i_cfg_index = 0; i_cfg_data = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // bytes before any start, then the extreme byte values
        add_str("GET / H1\r\n\r\n");
        send_req(0);
        push_byte(0, 8'h00);
        push_byte(0, 8'hFF);
        // request beginning with CR, and one with a single space
        add_str("\r");
        send_req(1);
        add_str("A B\r");
        send_req(1);
        // header-less, overflow, negative zero, negative, last line wins, plain length, value after a line feed
        add_str("G / H\r\n\r\n");
        send_req(1);
        add_str("G / H\r\nContent-Length: 99999\r\n\r\n");
        send_req(1);
        add_str("G / H\r\ncontent-length:-0\r\n\r\n");
        send_req(1);
        add_str("G / H\r\nCONTENT-LENGTH: -5\r\n\r\n");
        send_req(1);
        add_str("G / H\r\nContent-Length: 9\r\nContent-Length:\t+3\r\n\r\n");
        send_req(1);
        add_str("G / H\r\nContent-Length: 2\r\n\r\n");
        send_req(1);
        add_str("G / H\r\nContent-Length: \n 1");
        add_str("\r\n\r\n");
        send_req(1);

        write_cfg(CFG_BODY_LIMIT, 15'd0);
        add_str("G / H\r\nContent-Length: 1\r\n\r\n");
        send_req(1);
        write_cfg(CFG_HEADER_LIMIT, 15'd4);
        add_str("G / H\r\n\r\n");
        send_req(1);
        random_traffic(30);

        write_cfg(CFG_HEADER_LIMIT, 15'h7FFF);
        write_cfg(CFG_BODY_LIMIT, 15'h7FFF);
        random_traffic(80);

        write_cfg(CFG_HEADER_LIMIT, 15'd30);
        write_cfg(CFG_BODY_LIMIT, 15'd4);
        random_traffic(60);

        write_cfg(CFG_HEADER_LIMIT, 15'd8192);
        write_cfg(CFG_BODY_LIMIT, 15'd16384);
        random_traffic(60);

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        if (sb.fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hrp_pkg.sv
rtl/core/hrp_front.sv
rtl/core/hrp_queue.sv
rtl/core/http_request_header_parser.sv
dv/testbench.sv
